### hw/rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions for the SHA-256 message hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  // Control bundle from the sequencer to the datapath
  typedef struct packed {
    logic        shift_byte;
    logic [7:0]  byte_val;
    logic        shift_len;
    logic [63:0] len;
    logic        load_vars;
    logic        round_en;
    logic [5:0]  rnd;
    logic        add_back;
    logic        reset_hash;
  } ctl_t;

  localparam logic [5:0]  LEN_POS    = 6'd56;
  localparam logic [5:0]  LAST_BYTE  = 6'd63;
  localparam logic [5:0]  LAST_ROUND = 6'd63;
  localparam logic [2:0]  LAST_WORD  = 3'd7;
  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [63:0] LEN_STEP   = 64'd8;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
    rotr = (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] v);
    big_sig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] v);
    big_sig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] v);
    small_sig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] v);
    small_sig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    choose = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    majority = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

### hw/rtl/sha256_if.sv
// ----------------------------------------------------------------------------
// sha256 channel interfaces
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### hw/rtl/sha256_core.sv
// ----------------------------------------------------------------------------
// sha256_core
// Block shift line, working variables, shared round unit and hash state.
// ----------------------------------------------------------------------------
module sha256_core (
  input  logic                clk,
  input  logic                rst,
  input  sha256_pkg::ctl_t    ctl,
  output logic [31:0]         hash [8]
);

  // Block shift line: oldest word W(t) sits in the top 32 bits
  logic [511:0] blk;
  logic [31:0]  wv [8];
  logic [31:0]  w_new;
  logic [31:0]  t1;
  logic [31:0]  t2;

  // Shared round unit and schedule step
  always_comb begin
    w_new = sha256_pkg::small_sig1(blk[63:32]) + blk[223:192] +
            sha256_pkg::small_sig0(blk[479:448]) + blk[511:480];
    t1 = wv[7] + sha256_pkg::big_sig1(wv[4]) +
         sha256_pkg::choose(wv[4], wv[5], wv[6]) +
         sha256_pkg::K_TABLE[ctl.rnd] + blk[511:480];
    t2 = sha256_pkg::big_sig0(wv[0]) + sha256_pkg::majority(wv[0], wv[1], wv[2]);
  end

  // Advance the shift line: bytes, length, or schedule words
  always_ff @(posedge clk) begin
    if (ctl.shift_byte) begin
      blk <= {blk[503:0], ctl.byte_val};
    end else if (ctl.shift_len) begin
      blk <= {blk[447:0], ctl.len};
    end else if (ctl.round_en) begin
      blk <= {blk[479:0], w_new};
    end
  end

  // Load and update working variables
  always_ff @(posedge clk) begin
    if (ctl.load_vars) begin
      wv <= hash;
    end else if (ctl.round_en) begin
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
  end

  // Hold the chaining value; add back after each block
  always_ff @(posedge clk) begin
    if (rst || ctl.reset_hash) begin
      hash <= sha256_pkg::H_INIT;
    end else if (ctl.add_back) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= hash[i] + wv[i];
      end
    end
  end

endmodule

### hw/rtl/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer: byte intake, padding, round count and digest word readout.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        in_data,
  input  logic              in_present,
  input  logic              in_end,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_idx,
  output sha256_pkg::ctl_t  ctl
);

  sha256_pkg::state_t state;
  sha256_pkg::state_t state_next;

  logic [5:0]  cnt;
  logic [5:0]  rnd;
  logic [63:0] len;
  logic        pad_first;
  logic        finish_pending;
  logic        final_blk;
  logic        in_acc;
  logic        out_acc;

  assign in_acc  = in_valid && (state == sha256_pkg::ST_IDLE);
  assign out_acc = out_ready && (state == sha256_pkg::ST_OUT);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sha256_pkg::ST_IDLE: begin
        if (ctl.load_vars) begin
          state_next = sha256_pkg::ST_ROUND;
        end else if (in_acc && in_end) begin
          state_next = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_PAD: begin
        if (ctl.load_vars) begin
          state_next = sha256_pkg::ST_ROUND;
        end
      end
      sha256_pkg::ST_ROUND: begin
        if (rnd == sha256_pkg::LAST_ROUND) begin
          state_next = sha256_pkg::ST_ADD;
        end
      end
      sha256_pkg::ST_ADD: begin
        if (final_blk) begin
          state_next = sha256_pkg::ST_OUT;
        end else if (finish_pending) begin
          state_next = sha256_pkg::ST_PAD;
        end else begin
          state_next = sha256_pkg::ST_IDLE;
        end
      end
      sha256_pkg::ST_OUT: begin
        if (out_acc && out_idx == sha256_pkg::LAST_WORD) begin
          state_next = sha256_pkg::ST_IDLE;
        end
      end
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    in_ready       = (state == sha256_pkg::ST_IDLE);
    out_valid      = (state == sha256_pkg::ST_OUT);
    ctl            = '0;
    ctl.len        = len;
    ctl.rnd        = rnd;
    case (state)
      sha256_pkg::ST_IDLE: begin
        ctl.shift_byte = in_valid && in_present;
        ctl.byte_val   = in_data;
        ctl.load_vars  = ctl.shift_byte && (cnt == sha256_pkg::LAST_BYTE);
      end
      sha256_pkg::ST_PAD: begin
        ctl.shift_len  = !pad_first && (cnt == sha256_pkg::LEN_POS);
        ctl.shift_byte = !ctl.shift_len;
        ctl.byte_val   = pad_first ? sha256_pkg::PAD_BYTE : 8'h00;
        ctl.load_vars  = ctl.shift_len || (cnt == sha256_pkg::LAST_BYTE);
      end
      sha256_pkg::ST_ROUND: ctl.round_en = 1'b1;
      sha256_pkg::ST_ADD:   ctl.add_back = 1'b1;
      sha256_pkg::ST_OUT:   ctl.reset_hash = out_ready && (out_idx == sha256_pkg::LAST_WORD);
      default: ctl.round_en = 1'b0;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= sha256_pkg::ST_IDLE;
      cnt            <= '0;
      rnd            <= '0;
      len            <= '0;
      out_idx        <= '0;
      pad_first      <= 1'b0;
      finish_pending <= 1'b0;
      final_blk      <= 1'b0;
    end else begin
      state <= state_next;
      // count bytes in the block, wrap at the block end
      if (ctl.shift_byte) begin
        cnt <= cnt + 6'd1;
      end else if (ctl.shift_len) begin
        cnt <= '0;
      end
      if (in_acc && in_present) begin
        len <= len + sha256_pkg::LEN_STEP;
      end
      if (in_acc && in_end) begin
        pad_first      <= 1'b1;
        finish_pending <= 1'b1;
      end
      if (state == sha256_pkg::ST_PAD && pad_first) begin
        pad_first <= 1'b0;
      end
      if (ctl.shift_len) begin
        final_blk <= 1'b1;
      end
      if (ctl.round_en) begin
        rnd <= rnd + 6'd1;
      end
      // drop message state after the last digest beat
      if (out_acc) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == sha256_pkg::LAST_WORD) begin
          final_blk      <= 1'b0;
          finish_pending <= 1'b0;
          len            <= '0;
        end
      end
    end
  end

endmodule

### hw/rtl/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 over a byte stream, one round per cycle on a shared round unit.
// ----------------------------------------------------------------------------
// Usage:
//   msg    : input beats carry data_byte (valid when byte_present) and
//            end_of_message. A beat with neither changes nothing.
//   digest : eight output beats per message, h0 first, word_index 0..7,
//            last_word set on h7.
// Sequence:
//   Completing a 64-byte block runs the 64 rounds on the single round unit
//   and then the add-back, with msg.ready low; other byte beats are
//   accepted directly.
//   At end of message the sequencer shifts in padding one byte a cycle,
//   then compresses one or two blocks and presents the digest words one a
//   cycle while the receiver is ready.
// Stall:
//   The digest waits in the hash register; a stalled receiver holds the
//   current word and no new input beat is taken until the last word goes.
// Reset:
//   Synchronous rst restores the initial hash and clears the byte count,
//   the bit length and the sequencer.
// ----------------------------------------------------------------------------
module sha256_message_hasher (
  input  logic                clk,
  input  logic                rst,
  sha256_in_if.sink           msg,
  sha256_out_if.source        digest
);

  sha256_pkg::ctl_t ctl;
  logic [31:0]      hash [8];
  logic [2:0]       out_idx;

  sha256_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (msg.valid),
    .in_data    (msg.data_byte),
    .in_present (msg.byte_present),
    .in_end     (msg.end_of_message),
    .in_ready   (msg.ready),
    .out_valid  (digest.valid),
    .out_ready  (digest.ready),
    .out_idx    (out_idx),
    .ctl        (ctl)
  );

  sha256_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .hash (hash)
  );

  // Present the selected digest word
  assign digest.digest_word = hash[out_idx];
  assign digest.word_index  = out_idx;
  assign digest.last_word   = (out_idx == sha256_pkg::LAST_WORD);

endmodule

### hw/rtl/sha256_checker.sv
// ----------------------------------------------------------------------------
// sha256_checker
// Port-level checks on the hasher's beat sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // Input and output never open together
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while digest valid");

  // An end-of-message beat closes the input
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_end) |=> !in_ready)
    else $error("input still ready after end of message");

  // Digest words advance by one
  a_word_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_word) |=>
      (out_valid && word_index == 3'($past(word_index) + 3'd1)))
    else $error("digest word sequence broken");

  // Last word ends the digest
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_word) |=> (!out_valid && in_ready))
    else $error("digest continues after last word");

endmodule

bind sha256_message_hasher sha256_checker u_sha256_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (msg.valid),
  .in_ready   (msg.ready),
  .in_end     (msg.end_of_message),
  .out_valid  (digest.valid),
  .out_ready  (digest.ready),
  .word_index (digest.word_index),
  .last_word  (digest.last_word)
);
